>>> sv/spq_pkg.sv
// package: types and constants of the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DEPTH       = 64;
  localparam int COST_BITS   = 32;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int OCC_W       = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    logic [COST_BITS-1:0]   cost;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

>>> sv/spq_if.sv
// interfaces: operation channel and result channel
`timescale 1ns / 1ps
interface spq_in_if;
  import spq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [COST_BITS-1:0]   cost;
  logic [HANDLE_BITS-1:0] handle;

  modport source (output valid, output op, output cost, output handle, input ready);
  modport sink (input valid, input op, input cost, input handle, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   got_entry;
  logic [COST_BITS-1:0]   out_cost;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   dropped;
  logic                   is_empty;
  logic [OCC_W-1:0]       occupancy;

  modport source (output valid, output got_entry, output out_cost, output out_handle,
                  output dropped, output is_empty, output occupancy, input ready);
  modport sink (input valid, input got_entry, input out_cost, input out_handle,
                input dropped, input is_empty, input occupancy, output ready);
endinterface

>>> sv/sorted_priority_queue.sv
// top level: sorted min-priority queue built as a row of shifting cells
//
//   channel | dir | beat contents
//   in_ch   | in  | op, cost, handle
//   out_ch  | out | got_entry, out_cost, out_handle, dropped, is_empty, occupancy
//
// one op per cycle unless stalled; each cell compares its cost to the new one in parallel
// the result appears in the output register the cycle after the input beat
// rst_n (synchronous) empties the queue; stored entries are kept but not read
// a new beat is taken while the output register is empty or being drained
`timescale 1ns / 1ps
module sorted_priority_queue (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             got_r, got_nxt;
  logic             drop_r, drop_nxt;
  entry_t           res_r, res_nxt;
  logic             empty_r, empty_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  logic       accept;
  logic       full;
  entry_t     new_entry;
  cell_ctrl_t ctrl;
  entry_t     cell_q [DEPTH];
  logic       shift  [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r == CNT_W'(DEPTH));
  assign new_entry   = '{cost: in_ch.cost, handle: in_ch.handle};

  assign ctrl.ins_en = accept && (in_ch.op == OP_INSERT);
  assign ctrl.rem_en = accept && (in_ch.op == OP_REMOVE) && (cnt_r != '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_s;
    entry_t right_e;
    logic   occ;

    assign occ = (CNT_W'(i) < cnt_r);

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_s = shift[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_shift  (left_s),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .shift       (shift[i])
    );
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    got_nxt       = got_r;
    drop_nxt      = drop_r;
    res_nxt       = res_r;
    empty_nxt     = empty_r;
    occ_nxt       = occ_r;
    if (accept) begin
      got_nxt  = 1'b0;
      drop_nxt = 1'b0;
      res_nxt  = '0;
      unique case (in_ch.op)
        OP_INSERT: begin
          if (full) begin
            drop_nxt = 1'b1;
            res_nxt  = shift[DEPTH-1] ? cell_q[DEPTH-1] : new_entry;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (cnt_r != '0) begin
            got_nxt = 1'b1;
            res_nxt = cell_q[0];
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
      out_valid_nxt = 1'b1;
      empty_nxt     = (cnt_nxt == '0);
      occ_nxt       = OCC_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    got_r   <= got_nxt;
    drop_r  <= drop_nxt;
    res_r   <= res_nxt;
    empty_r <= empty_nxt;
    occ_r   <= occ_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.got_entry  = got_r;
  assign out_ch.out_cost   = res_r.cost;
  assign out_ch.out_handle = res_r.handle;
  assign out_ch.dropped    = drop_r;
  assign out_ch.is_empty   = empty_r;
  assign out_ch.occupancy  = occ_r;

endmodule

>>> sv/spq_cell.sv
// one queue cell: holds an entry, shifts right on insert and left on remove
`timescale 1ns / 1ps
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  spq_pkg::entry_t     new_entry,
  input  spq_pkg::entry_t     left_entry,
  input  logic                left_shift,
  input  spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t     entry,
  output logic                shift
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // cells past the fill point and costlier cells move right on insert
  assign shift = !occ || (entry_r.cost > new_entry.cost);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.rem_en) begin
      entry_nxt = right_entry;
    end else if (ctrl.ins_en) begin
      priority if (left_shift) begin
        entry_nxt = left_entry;
      end else if (shift) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = entry_r;
      end
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> sv/spq_check.sv
// checker: port-level properties of the sorted priority queue, bound to the top level
`timescale 1ns / 1ps
module spq_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            got_entry,
  input logic                            dropped,
  input logic                            is_empty,
  input logic [spq_pkg::OCC_W-1:0]       occupancy,
  input logic [spq_pkg::COST_BITS-1:0]   out_cost
);
  import spq_pkg::*;

  // no beat taken while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("input beat taken over a stalled result");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after an input beat");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((is_empty == (occupancy == '0)) && (occupancy <= OCC_W'(DEPTH))))
    else $error("empty flag or occupancy inconsistent");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(got_entry && dropped) && (!dropped || (occupancy == OCC_W'(DEPTH))))
    else $error("remove and drop flags inconsistent");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_cost) && $stable(occupancy)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_check u_spq_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .got_entry (out_ch.got_entry),
  .dropped   (out_ch.dropped),
  .is_empty  (out_ch.is_empty),
  .occupancy (out_ch.occupancy),
  .out_cost  (out_ch.out_cost)
);
